@@ src/q15at_pkg.sv @@
package q15at_pkg;

  localparam int DefSteps = 16;
  localparam int MaxSteps = 24;

  // x/y carry the input scaled by 2^16 plus the cordic gain and a sign bit
  localparam int XyW = 36;
  // z is half-turns with 24 fraction bits, the start offset plus the table sum fits
  localparam int ZW = 27;

  localparam logic signed [ZW-1:0] HalfTurn = 27'sd16777216;

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cell_data_t;

  // round(atan(2^-idx) / pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 27'sd4194304;
      1:       val = 27'sd2476042;
      2:       val = 27'sd1308273;
      3:       val = 27'sd664100;
      4:       val = 27'sd333339;
      5:       val = 27'sd166832;
      6:       val = 27'sd83436;
      7:       val = 27'sd41721;
      8:       val = 27'sd20861;
      9:       val = 27'sd10430;
      10:      val = 27'sd5215;
      11:      val = 27'sd2608;
      12:      val = 27'sd1304;
      13:      val = 27'sd652;
      14:      val = 27'sd326;
      15:      val = 27'sd163;
      16:      val = 27'sd81;
      17:      val = 27'sd41;
      18:      val = 27'sd20;
      19:      val = 27'sd10;
      20:      val = 27'sd5;
      21:      val = 27'sd3;
      22:      val = 27'sd1;
      23:      val = 27'sd1;
      default: val = 27'sd0;
    endcase
    return val;
  endfunction

endpackage

@@ src/q15_atan2_half_turns_core.sv @@
// four-quadrant atan2(emf_beta, emf_alpha) in half-turns, q15 (32767 = pi), from a
// pipelined vectoring cordic with one cell per iteration. a new item is taken every
// cycle: busy is always low. the result appears on angle with done high for one cycle,
// after it has passed through one registered cordic cell per iteration and then the
// scaling register. nothing holds results back, so the receiver must take them as they come.
// if either input is zero the angle is 0.
module q15_atan2_half_turns_core #(
  parameter int CORDIC_STEPS = q15at_pkg::DefSteps
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] emf_alpha,
  input  logic signed [15:0] emf_beta,
  output logic               done,
  output logic signed [15:0] angle
);

  localparam int Cells = (CORDIC_STEPS > q15at_pkg::MaxSteps) ?
                         q15at_pkg::MaxSteps : CORDIC_STEPS;
  localparam int Lat   = Cells + 1;

  q15at_pkg::cell_data_t            chain [Cells+1];
  q15at_pkg::cell_data_t            head;
  logic signed [q15at_pkg::XyW-1:0] x0;
  logic signed [q15at_pkg::XyW-1:0] y0;

  assign busy = 1'b0;

  always_comb begin
    x0 = {{(q15at_pkg::XyW-32){emf_alpha[15]}}, emf_alpha, 16'h0000};
    y0 = {{(q15at_pkg::XyW-32){emf_beta[15]}}, emf_beta, 16'h0000};
    head.valid = start && !busy;
    head.zero  = (emf_alpha == 16'sd0) || (emf_beta == 16'sd0);
    // left half-plane: flip the vector and start from plus or minus pi
    if (emf_alpha[15]) begin
      head.x = -x0;
      head.y = -y0;
      head.z = (!emf_beta[15] && emf_beta != 16'sd0) ?
               q15at_pkg::HalfTurn : -q15at_pkg::HalfTurn;
    end else begin
      head.x = x0;
      head.y = y0;
      head.z = '0;
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    q15at_cell #(
      .Idx(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  q15at_post u_post (
    .clk  (clk),
    .rst  (rst),
    .d_in (chain[Cells]),
    .done (done),
    .angle(angle)
  );

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Lat))
    else $error("result strobe without a matching start");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> angle != 16'sh8000)
    else $error("angle outside the q15 half-turn range");

  a_zero_input: assert property (@(posedge clk) disable iff (rst)
    done && ($past(emf_alpha, Lat) == 16'sd0 || $past(emf_beta, Lat) == 16'sd0)
      |-> angle == 16'sd0)
    else $error("zero component did not give a zero angle");

endmodule

@@ src/q15at_cell.sv @@
module q15at_cell #(
  parameter int Idx = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  q15at_pkg::cell_data_t d_in,
  output q15at_pkg::cell_data_t d_out
);

  localparam logic signed [q15at_pkg::ZW-1:0] Step = q15at_pkg::atan_entry(Idx);

  logic signed [q15at_pkg::XyW-1:0] xs;
  logic signed [q15at_pkg::XyW-1:0] ys;
  q15at_pkg::cell_data_t            d_next;

  always_comb begin
    xs = d_in.x >>> Idx;
    ys = d_in.y >>> Idx;
    d_next = d_in;
    // rotate toward the x axis
    if (!d_in.y[q15at_pkg::XyW-1]) begin
      d_next.x = d_in.x + ys;
      d_next.y = d_in.y - xs;
      d_next.z = d_in.z + Step;
    end else begin
      d_next.x = d_in.x - ys;
      d_next.y = d_in.y + xs;
      d_next.z = d_in.z - Step;
    end
  end

  always_ff @(posedge clk) begin
    d_out.zero <= d_next.zero;
    d_out.x    <= d_next.x;
    d_out.y    <= d_next.y;
    d_out.z    <= d_next.z;
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= d_next.valid;
    end
  end

endmodule

@@ src/q15at_post.sv @@
module q15at_post (
  input  logic                  clk,
  input  logic                  rst,
  input  q15at_pkg::cell_data_t d_in,
  output logic                  done,
  output logic signed [15:0]    angle
);

  localparam int MagW  = q15at_pkg::ZW - 2;
  localparam int ProdW = MagW + 15;

  logic signed [q15at_pkg::ZW-1:0] zc;
  logic                            neg;
  logic [MagW-1:0]                 mag;
  logic [ProdW-1:0]                prod;
  logic [15:0]                     res;
  logic signed [15:0]              angle_next;

  always_comb begin
    zc = d_in.z;
    if (d_in.z > q15at_pkg::HalfTurn) begin
      zc = q15at_pkg::HalfTurn;
    end else if (d_in.z < -q15at_pkg::HalfTurn) begin
      zc = -q15at_pkg::HalfTurn;
    end
    neg = zc[q15at_pkg::ZW-1];
    mag = neg ? MagW'(-zc) : MagW'(zc);
    // mag * 32767 as a shift and subtract
    prod = {mag, 15'h0000} - {15'h0000, mag};
    res  = prod[ProdW-1 -: 16];
    if (d_in.zero) begin
      angle_next = 16'sd0;
    end else if (neg) begin
      angle_next = -$signed(res);
    end else begin
      angle_next = $signed(res);
    end
  end

  always_ff @(posedge clk) begin
    angle <= angle_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_in.valid;
    end
  end

endmodule

@@ tb/sv/q15_atan2_half_turns_core_tb.sv @@
`timescale 1ns / 1ps

module q15_atan2_half_turns_core_tb;

  localparam int Steps = q15at_pkg::DefSteps;
  localparam int TableLen = 24;
  localparam longint HalfTurnHt = 64'sd16777216;
  localparam int StallLimit = 2000;
  localparam int NumRandom = 1000;

  // atan(2^-i) / pi in half-turns, 24 fraction bits
  localparam longint AtanHt [TableLen] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  class angle_tracker;
    logic signed [15:0] expected_angles[$];
    int errors;
    int steps;

    function new(int n);
      steps = n;
      errors = 0;
    endfunction

    function logic signed [15:0] predict_angle(logic signed [15:0] a, logic signed [15:0] b);
      longint x, y, z, xs, ys, mag;
      int n, i;
      if (a == 0 || b == 0) return 16'sd0;
      x = longint'(a) * 65536;
      y = longint'(b) * 65536;
      z = 0;
      // fold the left half-plane onto the right one
      if (x < 0) begin
        z = (b > 0) ? HalfTurnHt : -HalfTurnHt;
        x = -x;
        y = -y;
      end
      n = (steps > TableLen) ? TableLen : steps;
      for (i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + AtanHt[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - AtanHt[i];
        end
      end
      if (z > HalfTurnHt) z = HalfTurnHt;
      if (z < -HalfTurnHt) z = -HalfTurnHt;
      mag = (((z < 0) ? -z : z) * 32767) >>> 24;
      return (z < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    function void note_item(logic signed [15:0] a, logic signed [15:0] b);
      expected_angles.push_back(predict_angle(a, b));
    endfunction

    function void check_angle(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result angle=%0d", $time, got);
        errors++;
        return;
      end
      want = expected_angles.pop_front();
      if (got !== want) begin
        $display("%0t: angle mismatch expected=%0d actual=%0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] emf_alpha;
  logic signed [15:0] emf_beta;
  logic done;
  logic signed [15:0] angle;

  angle_tracker tracker;
  int idle_pct;
  int stall_cycles;

  q15_atan2_half_turns_core #(
    .CORDIC_STEPS(Steps)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .emf_alpha (emf_alpha),
    .emf_beta  (emf_beta),
    .done      (done),
    .angle     (angle)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // input acceptance and result checking, both on the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) tracker.note_item(emf_alpha, emf_beta);
      if (done === 1'b1) tracker.check_angle(angle);
    end
  end

  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("FAIL q15_atan2_half_turns_core");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic signed [15:0] a, logic signed [15:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    emf_alpha <= a;
    emf_beta <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_all_done();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic signed [15:0] a, b;
    int pick;
    pick = $urandom_range(0, 99);
    a = 16'($urandom());
    b = 16'($urandom());
    if (pick >= 60 && pick < 80) begin
      // small vectors, where the shifted terms vanish fastest
      a = 16'($urandom_range(0, 64) - 32);
      b = 16'($urandom_range(0, 64) - 32);
    end else if (pick >= 80 && pick < 90) begin
      case ($urandom_range(0, 3))
        0: a = -16'sd32768;
        1: a = 16'sd32767;
        2: a = -16'sd1;
        default: a = 16'sd1;
      endcase
    end else if (pick >= 90) begin
      // one zero component forces a zero angle
      if ($urandom_range(0, 1)) a = 16'sd0;
      else b = 16'sd0;
    end
    send_item(a, b);
  endtask

  initial begin
    tracker = new(Steps);
    rst = 1'b1;
    start = 1'b0;
    emf_alpha = 16'sd0;
    emf_beta = 16'sd0;
    stall_cycles = 0;
    idle_pct = 30;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // axes, corners and the near-pi region of the left half-plane
    send_item(16'sd0, 16'sd0);
    send_item(16'sd32767, 16'sd0);
    send_item(-16'sd32768, 16'sd0);
    send_item(16'sd0, 16'sd32767);
    send_item(16'sd0, -16'sd32768);
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);
    send_item(-16'sd32768, 16'sd32767);
    send_item(16'sd32767, -16'sd32768);
    send_item(16'sd1, 16'sd1);
    send_item(-16'sd1, -16'sd1);
    send_item(-16'sd1, 16'sd1);
    send_item(16'sd1, -16'sd1);
    send_item(-16'sd32768, 16'sd1);
    send_item(-16'sd32768, -16'sd1);
    send_item(-16'sd1, 16'sd32767);
    send_item(-16'sd1, -16'sd32768);
    send_item(16'sd32767, 16'sd1);
    send_item(16'sd32767, -16'sd1);
    send_item(16'sd1, 16'sd32767);
    send_item(16'sd1, -16'sd32768);
    wait_all_done();

    for (int n = 0; n < NumRandom; n++) begin
      // back-to-back stretch in the middle of the run
      idle_pct = (n >= 300 && n < 600) ? 0 : 30;
      if (n == 700) wait_all_done();
      send_random_item();
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (Steps + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS q15_atan2_half_turns_core");
    end else begin
      $display("FAIL q15_atan2_half_turns_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/q15at_pkg.sv
src/q15at_cell.sv
src/q15at_post.sv
src/q15_atan2_half_turns_core.sv
tb/sv/q15_atan2_half_turns_core_tb.sv
